[src/mrr_pkg.sv]
`default_nettype none
package mrr_pkg;
  localparam int NUM_BITS_DEF = 63;
  localparam int FIELD_W = 63;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SPLIT,
    ST_MUL_INIT,
    ST_MUL_STEP,
    ST_MUL_DONE,
    ST_SQUARE_CHECK,
    ST_JUDGE,
    ST_OUTPUT
  } state_t;

  // what the current multiplication feeds
  typedef enum logic [1:0] {
    MUL_ACC,
    MUL_BASE,
    MUL_SQR
  } mul_op_t;
endpackage
`default_nettype wire

[src/mrr_if.sv]
`default_nettype none
interface mrr_in_if;
  logic                        valid;
  logic                        ready;
  logic [mrr_pkg::FIELD_W-1:0] candidate;
  logic [mrr_pkg::FIELD_W-1:0] random_draw;
  logic                        first_round;
  logic                        last_round;
  modport source (output valid, candidate, random_draw, first_round, last_round,
                  input ready);
  modport sink   (input valid, candidate, random_draw, first_round, last_round,
                  output ready);
endinterface

interface mrr_out_if;
  logic valid;
  logic ready;
  logic probably_prime;
  logic final_res;
  modport source (output valid, probably_prime, final_res, input ready);
  modport sink   (input valid, probably_prime, final_res, output ready);
endinterface
`default_nettype wire

[src/miller_rabin_round_top.sv]
// channel | direction | payload
// in_     | sink      | candidate, random_draw, first_round, last_round
// out_    | source    | probably_prime, final_res
// one transaction at a time; n below 2 or even goes straight to the verdict
// the witness reduction is restoring division, one quotient bit per cycle
// each modular multiply is bit-serial, one multiplier bit per cycle
// a full round is about 2*NUM_BITS multiplies
// reset: synchronous, active low; clears the control and composite flag
// out stalls hold the result; a new input transaction is taken once the result leaves
`default_nettype none
module miller_rabin_round_top #(
  parameter int NUM_BITS = mrr_pkg::NUM_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mrr_in_if.sink    in_ch,
  mrr_out_if.source out_ch
);
  localparam int CW = $clog2(NUM_BITS + 1);

  mrr_pkg::state_t state_r, state_nxt;
  mrr_pkg::mul_op_t op_r, op_nxt;

  // datapath registers; rem_r and prod_r are one bit wider to hold sums below 2n
  logic [NUM_BITS-1:0] n_r, nm1_r, a_r, acc_r, u_r, x_r, mq_r, mx_r;
  logic [NUM_BITS:0]   rem_r, prod_r;
  logic [NUM_BITS-1:0] dq_r;
  logic [CW-1:0]       cnt_r, t_r, i_r;
  logic                last_r, comp_r, seen_r, outv_r, pp_r, fin_r, bad_r;

  logic [NUM_BITS-1:0] n_in, d_in;
  assign n_in = in_ch.candidate[NUM_BITS-1:0];
  assign d_in = in_ch.random_draw[NUM_BITS-1:0];

  // one shift-and-subtract step for the remainder
  logic [NUM_BITS:0] rem_sh;
  assign rem_sh = {rem_r[NUM_BITS-1:0], dq_r[NUM_BITS-1]};

  // one bit-serial multiply step: r = 2r (+x) mod n
  logic [NUM_BITS:0] dbl, dbl_m, add1, add_m;
  assign dbl   = {prod_r[NUM_BITS-1:0], 1'b0};
  assign dbl_m = (dbl >= {1'b0, n_r}) ? dbl - {1'b0, n_r} : dbl;
  assign add1  = dbl_m + {1'b0, mx_r};
  assign add_m = (add1 >= {1'b0, n_r}) ? add1 - {1'b0, n_r} : add1;

  logic [NUM_BITS-1:0] one;
  assign one = {{(NUM_BITS-1){1'b0}}, 1'b1};

  // next state
  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    unique case (state_r)
      mrr_pkg::ST_IDLE:
        if (in_ch.valid && in_ch.ready) begin
          if (n_in < NUM_BITS'(2) || !n_in[0]) state_nxt = mrr_pkg::ST_JUDGE;
          else state_nxt = mrr_pkg::ST_REDUCE;
        end
      mrr_pkg::ST_REDUCE:
        if (cnt_r == CW'(NUM_BITS - 1)) state_nxt = mrr_pkg::ST_SPLIT;
      mrr_pkg::ST_SPLIT:
        if (u_r[0]) begin
          state_nxt = mrr_pkg::ST_MUL_INIT;
          op_nxt = mrr_pkg::MUL_ACC;
        end
      mrr_pkg::ST_MUL_INIT: state_nxt = mrr_pkg::ST_MUL_STEP;
      mrr_pkg::ST_MUL_STEP:
        if (cnt_r == CW'(NUM_BITS - 1)) state_nxt = mrr_pkg::ST_MUL_DONE;
      mrr_pkg::ST_MUL_DONE: begin
        unique case (op_r)
          mrr_pkg::MUL_ACC: begin
            op_nxt = mrr_pkg::MUL_BASE;
            state_nxt = mrr_pkg::ST_MUL_INIT;
          end
          mrr_pkg::MUL_BASE: begin
            // decide on the exponent as it stands after this shift
            state_nxt = mrr_pkg::ST_MUL_INIT;
            if (u_r[NUM_BITS-1:1] == '0) begin
              if (t_r == '0) state_nxt = mrr_pkg::ST_JUDGE;
              else op_nxt = mrr_pkg::MUL_SQR;
            end else if (u_r[1]) op_nxt = mrr_pkg::MUL_ACC;
            else op_nxt = mrr_pkg::MUL_BASE;
          end
          default: state_nxt = mrr_pkg::ST_SQUARE_CHECK;
        endcase
      end
      mrr_pkg::ST_SQUARE_CHECK:
        if (bad_r || i_r == t_r) state_nxt = mrr_pkg::ST_JUDGE;
        else state_nxt = mrr_pkg::ST_MUL_INIT;
      mrr_pkg::ST_JUDGE: state_nxt = mrr_pkg::ST_OUTPUT;
      mrr_pkg::ST_OUTPUT:
        if (!outv_r) state_nxt = mrr_pkg::ST_IDLE;
      default: state_nxt = mrr_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ch.ready = (state_r == mrr_pkg::ST_IDLE);
  end
  assign out_ch.valid = outv_r;
  assign out_ch.probably_prime = pp_r;
  assign out_ch.final_res = fin_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrr_pkg::ST_IDLE;
      op_r <= mrr_pkg::MUL_ACC;
      seen_r <= 1'b0;
      outv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
      if (state_r == mrr_pkg::ST_IDLE && in_ch.valid && in_ch.ready && in_ch.first_round)
        seen_r <= 1'b0;
      if (state_r == mrr_pkg::ST_JUDGE) begin
        outv_r <= 1'b1;
        if (comp_r) seen_r <= 1'b1;
      end else if (outv_r && out_ch.ready) outv_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      mrr_pkg::ST_IDLE: begin
        n_r <= n_in;
        nm1_r <= n_in - one;
        u_r <= n_in - one;
        dq_r <= d_in;
        rem_r <= '0;
        cnt_r <= '0;
        t_r <= '0;
        i_r <= '0;
        bad_r <= 1'b0;
        last_r <= in_ch.last_round;
        comp_r <= (n_in < NUM_BITS'(2)) || (!n_in[0] && n_in != NUM_BITS'(2));
        acc_r <= one;
      end
      mrr_pkg::ST_REDUCE: begin
        // restoring division by n-1
        if (rem_sh >= {1'b0, nm1_r}) rem_r <= rem_sh - {1'b0, nm1_r};
        else rem_r <= rem_sh;
        dq_r <= {dq_r[NUM_BITS-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NUM_BITS - 1)) begin
          if (rem_sh >= {1'b0, nm1_r}) a_r <= NUM_BITS'(rem_sh - {1'b0, nm1_r}) + one;
          else a_r <= rem_sh[NUM_BITS-1:0] + one;
        end
      end
      mrr_pkg::ST_SPLIT:
        if (!u_r[0]) begin
          u_r <= {1'b0, u_r[NUM_BITS-1:1]};
          t_r <= t_r + 1'b1;
        end
      mrr_pkg::ST_MUL_INIT: begin
        cnt_r <= '0;
        prod_r <= '0;
        unique case (op_r)
          mrr_pkg::MUL_ACC:  begin mx_r <= acc_r; mq_r <= a_r; end
          mrr_pkg::MUL_BASE: begin mx_r <= a_r;   mq_r <= a_r; end
          default:           begin mx_r <= x_r;   mq_r <= x_r; end
        endcase
      end
      mrr_pkg::ST_MUL_STEP: begin
        prod_r <= mq_r[NUM_BITS-1] ? add_m : dbl_m;
        mq_r <= {mq_r[NUM_BITS-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
      end
      mrr_pkg::ST_MUL_DONE:
        unique case (op_r)
          mrr_pkg::MUL_ACC: acc_r <= prod_r[NUM_BITS-1:0];
          mrr_pkg::MUL_BASE: begin
            a_r <= prod_r[NUM_BITS-1:0];
            u_r <= {1'b0, u_r[NUM_BITS-1:1]};
            if (u_r[NUM_BITS-1:1] == '0) x_r <= acc_r;
            if (u_r[NUM_BITS-1:1] == '0 && t_r == '0) comp_r <= (acc_r != one);
          end
          default: begin
            bad_r <= (prod_r[NUM_BITS-1:0] == one) && (x_r != one) && (x_r != nm1_r);
            x_r <= prod_r[NUM_BITS-1:0];
            i_r <= i_r + 1'b1;
          end
        endcase
      mrr_pkg::ST_SQUARE_CHECK: begin
        if (bad_r) comp_r <= 1'b1;
        else if (i_r == t_r) comp_r <= (x_r != one);
      end
      mrr_pkg::ST_JUDGE: begin
        pp_r <= !(seen_r || comp_r);
        fin_r <= last_r;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[src/mrr_checker.sv]
`default_nettype none
module mrr_assertions (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_probably_prime,
  input wire logic out_final_res
);
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_probably_prime)
      && $stable(out_final_res))
    else $error("stalled result changed");
  // no input while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready with pending result");
  // an accepted transaction is not answered in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");
endmodule

bind miller_rabin_round_top mrr_assertions u_mrr_assertions (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_probably_prime(out_ch.probably_prime), .out_final_res(out_ch.final_res)
);
`default_nettype wire

[verif/mrr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module mrr_checker #(
  parameter int NUM_BITS = mrr_pkg::NUM_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mrr_in_if         in_ch,
  mrr_out_if        out_ch,
  output int        verdicts_pending,
  output int        mismatch_count
);
  typedef bit [63:0] word_t;

  typedef struct packed {
    bit probably_prime;
    bit final_res;
  } verdict_t;

  localparam word_t NUM_MASK = (word_t'(1) << NUM_BITS) - 1;

  verdict_t verdict_q[$];
  bit       composite_flag;

  // (x + y) mod n for x, y below n
  function automatic word_t add_modn(word_t x, word_t y, word_t n);
    word_t s;
    s = x + y;
    return (s >= n) ? s - n : s;
  endfunction

  // shift and add modular product
  function automatic word_t mul_modn(word_t x, word_t y, word_t n);
    word_t r;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = add_modn(r, r, n);
      if (y[i]) r = add_modn(r, x, n);
    end
    return r;
  endfunction

  function automatic word_t pow_modn(word_t b, word_t e, word_t n);
    word_t acc;
    acc = 1 % n;
    while (e != 0) begin
      if (e[0]) acc = mul_modn(acc, b, n);
      b = mul_modn(b, b, n);
      e = e >> 1;
    end
    return acc;
  endfunction

  // witness a shows odd n >= 3 is composite
  function automatic bit witness_exposes(word_t a, word_t n);
    word_t u, x, nx;
    int    t;
    u = n - 1;
    t = 0;
    while (u[0] == 1'b0) begin
      u = u >> 1;
      t++;
    end
    x = pow_modn(a, u, n);
    for (int i = 0; i < t; i++) begin
      nx = mul_modn(x, x, n);
      if (nx == 1 && x != 1 && x != n - 1) return 1'b1;
      x = nx;
    end
    return x != 1;
  endfunction

  // one round's judgement; small and even numbers skip the witness
  function automatic bit round_rejects(word_t n, word_t draw);
    if (n < 2) return 1'b1;
    if (n[0] == 1'b0) return n != 2;
    return witness_exposes(draw % (n - 1) + 1, n);
  endfunction

  task automatic report_mismatch(string what, bit exp_v, bit got_v);
    $display("%0t mismatch on %s: expected %0b got %0b", $time, what, exp_v, got_v);
    mismatch_count++;
  endtask

  initial begin
    mismatch_count = 0;
    composite_flag = 1'b0;
    verdicts_pending = 0;
  end

  // predict on input transaction, compare on output transaction
  always @(posedge clk) begin
    verdict_t exp_v;
    word_t    n, draw;
    if (!rst_n) begin
      composite_flag = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        n    = word_t'(in_ch.candidate) & NUM_MASK;
        draw = word_t'(in_ch.random_draw) & NUM_MASK;
        if (in_ch.first_round) composite_flag = 1'b0;
        if (round_rejects(n, draw)) composite_flag = 1'b1;
        exp_v.probably_prime = !composite_flag;
        exp_v.final_res      = in_ch.last_round;
        verdict_q.push_back(exp_v);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected result transaction", 1'b0, 1'b1);
        end else begin
          exp_v = verdict_q.pop_front();
          if (out_ch.probably_prime !== exp_v.probably_prime)
            report_mismatch("probably_prime", exp_v.probably_prime, out_ch.probably_prime);
          if (out_ch.final_res !== exp_v.final_res)
            report_mismatch("final_res", exp_v.final_res, out_ch.final_res);
        end
      end
    end
    verdicts_pending <= verdict_q.size();
  end
endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  localparam longint CYCLE_LIMIT = 12_000_000;
  localparam bit [62:0] TOP_VAL = {63{1'b1}};

  logic clk;
  logic rst_n;
  int   verdicts_pending;
  int   mismatch_count;
  longint cycle_count;
  bit   no_idle;

  mrr_in_if  in_ch();
  mrr_out_if out_ch();

  miller_rabin_round_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mrr_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .verdicts_pending (verdicts_pending),
    .mismatch_count   (mismatch_count)
  );

  // known primes and hard composites for well-formed candidates
  bit [62:0] known_primes[] = '{63'd3, 63'd5, 63'd7, 63'd13, 63'd65537, 63'd1000000007,
                                63'd2305843009213693951, 63'd9223372036854775783,
                                63'd4294967291};
  bit [62:0] tricky_composites[] = '{63'd9, 63'd561, 63'd1105, 63'd2047, 63'd41041,
                                     63'd3215031751, 63'd4294967297};

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // mostly short gaps, a few long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic bit [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[miller_rabin_round_top] ERROR");
      $finish;
    end
  end

  // result side stalls
  int stall_left;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (pick_gap() > 0) begin
      stall_left <= pick_gap();
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_round(bit [62:0] cand, bit [62:0] draw, bit first, bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.candidate   <= cand;
    in_ch.random_draw <= draw;
    in_ch.first_round <= first;
    in_ch.last_round  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // a candidate checked over one to three rounds
  task automatic send_candidate(bit [62:0] cand);
    int rounds;
    rounds = $urandom_range(1, 3);
    for (int i = 0; i < rounds; i++)
      send_round(cand, rand63(), i == 0, i == rounds - 1);
  endtask

  function automatic bit [62:0] pick_candidate();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return known_primes[$urandom_range(0, known_primes.size() - 1)];
    if (r < 45) return tricky_composites[$urandom_range(0, tricky_composites.size() - 1)];
    if (r < 60) return 63'($urandom_range(0, 200));
    return rand63() | 63'd1;
  endfunction

  initial begin
    int sent;
    cycle_count = 0;
    stall_left  = 0;
    no_idle     = 1'b0;
    rst_n       = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.candidate   = '0;
    in_ch.random_draw = '0;
    in_ch.first_round = 1'b0;
    in_ch.last_round  = 1'b0;
    out_ch.ready      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rounds before any first round, small numbers, evens
    send_round(63'd7, 63'd0, 1'b0, 1'b0);
    send_round(63'd0, TOP_VAL, 1'b1, 1'b1);
    send_round(63'd1, 63'd5, 1'b1, 1'b1);
    send_round(63'd2, TOP_VAL, 1'b1, 1'b1);
    send_round(63'd4, 63'd0, 1'b1, 1'b1);
    send_round(63'd3, 63'd0, 1'b1, 1'b1);
    send_round(63'd3, TOP_VAL, 1'b1, 1'b1);
    // witness equal to n-1
    send_round(63'd13, 63'd11, 1'b1, 1'b0);
    send_round(63'd13, 63'd0, 1'b0, 1'b1);
    // strong pseudoprime to base 2, then a revealing witness
    send_round(63'd2047, 63'd1, 1'b1, 1'b0);
    send_round(63'd2047, 63'd2, 1'b0, 1'b1);
    send_round(63'd561, 63'd1, 1'b1, 1'b1);
    // flag sticks after last round; later candidate values ignored
    send_round(63'd5, 63'd3, 1'b0, 1'b0);
    send_round(TOP_VAL, TOP_VAL, 1'b1, 1'b1);
    send_round(63'd9223372036854775783, TOP_VAL, 1'b1, 1'b0);
    send_round(63'd9223372036854775783, 63'd0, 1'b0, 1'b1);
    send_round(63'd2305843009213693951, 63'h2aaa_aaaa_aaaa_aaaa, 1'b1, 1'b1);
    send_round(TOP_VAL - 63'd1, 63'h5555_5555_5555_5555, 1'b1, 1'b1);
    send_round(63'd4294967297, 63'd3, 1'b1, 1'b1);

    // hold off until every verdict is back
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);

    // random: mostly well-formed candidates, some noise with random flags
    sent = 0;
    while (sent < 100) begin
      no_idle = (sent >= 40 && sent < 55);
      if ($urandom_range(0, 9) < 8) begin
        send_candidate(pick_candidate());
        sent += 2;
      end else begin
        send_round($urandom_range(0, 1) ? rand63() : pick_candidate(), rand63(),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[miller_rabin_round_top] OK");
    end else begin
      $display("[miller_rabin_round_top] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
src/mrr_pkg.sv
src/mrr_if.sv
src/miller_rabin_round_top.sv
src/mrr_checker.sv
verif/mrr_checker.sv
verif/testbench.sv
